>>> sv/sorted_array_list_engine_unit_defines.svh
// Assertion macros used by the sorted array list engine top level.
`ifndef SORTED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define SALE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sale assertion failed");

`define SALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sale assertion failed");

`else

`define SALE_ASSERT_IMP(label, ante, cons)

`define SALE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/sale_pkg.sv
// Types and constants of the sorted array list engine.
package sale_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W + 1 : 6;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_SORT   = 3'd3;
    localparam logic [2:0] ACT_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  position;
        logic [15:0] entry_key;
        logic [31:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_index;
        logic [31:0] found_payload;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] payload;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_SORT_RD_I,
        S_SORT_LD_I,
        S_SORT_RD_J,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FINISH
    } state_t;

endpackage

>>> sv/sale_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sale_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sorted_array_list_engine_unit.sv
// Top level of the sorted array list engine: sequencer around one record RAM.
//
// Holds up to 16 records (16-bit key, 32-bit payload) in one RAM with a single
// read port whose read data are registered; every record move is a read then a
// write. Errors and unknown actions go straight to the result; insert and remove
// move the records behind the position one at a time; search probes at most 5
// records; sort is an insertion sort, its record shifts dominating. A new item
// is taken only once the previous one has left the sequencer; a finished result
// waits in the output register and does not hold up the next item's work.
`include "sorted_array_list_engine_unit_defines.svh"

module sorted_array_list_engine_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sale_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sale_pkg::rsp_t  rsp
);

    sale_pkg::state_t state_reg, state_next;

    logic [sale_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [sale_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic [sale_pkg::CNT_W-1:0]  i_reg, i_next;
    logic [sale_pkg::CNT_W-1:0]  j_reg, j_next;
    logic [sale_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [sale_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [sale_pkg::ADDR_W-1:0] mid_reg, mid_next;
    logic [15:0]                 key_reg, key_next;
    logic [31:0]                 pay_reg, pay_next;
    logic [1:0]                  status_reg, status_next;
    logic [3:0]                  fidx_reg, fidx_next;
    logic [31:0]                 fpay_reg, fpay_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    sale_pkg::rsp_t              rsp_reg, rsp_next;

    logic                        ram_we;
    logic [sale_pkg::ADDR_W-1:0] ram_waddr;
    sale_pkg::rec_t              ram_wdata;
    logic [sale_pkg::ADDR_W-1:0] ram_raddr;
    logic [$bits(sale_pkg::rec_t)-1:0] ram_rdata;
    sale_pkg::rec_t              rd_rec;

    logic                        accept;
    logic                        rsp_free;
    logic                        list_full;
    logic [sale_pkg::CMP_W-1:0]  count_ext;
    logic [sale_pkg::CMP_W-1:0]  ins_pos_ext;
    logic [sale_pkg::CMP_W-1:0]  rem_pos_ext;
    logic                        ins_bad_pos;
    logic                        rem_bad;
    logic                        rem_last;
    logic [sale_pkg::CNT_W:0]    mid_sum;
    logic [sale_pkg::ADDR_W-1:0] mid_calc;
    logic                        srch_hit;
    logic                        srch_less;
    logic [sale_pkg::CNT_W-1:0]  lo_step;
    logic [sale_pkg::CNT_W-1:0]  hi_step;
    logic                        srch_end;
    logic                        ins_end;
    logic                        rem_end;
    logic                        sort_end;
    logic                        sort_shift;

    sale_ram #(
        .WIDTH ($bits(sale_pkg::rec_t)),
        .DEPTH (sale_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec    = sale_pkg::rec_t'(ram_rdata);
    assign req_stall = (state_reg != sale_pkg::S_IDLE);
    assign accept    = req_valid && (state_reg == sale_pkg::S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign list_full   = (count_reg == sale_pkg::CNT_W'(sale_pkg::DEPTH));
    assign count_ext   = sale_pkg::CMP_W'(count_reg);
    assign rem_pos_ext = sale_pkg::CMP_W'(req.position);
    assign ins_pos_ext = (req.action == sale_pkg::ACT_APPEND) ? count_ext : rem_pos_ext;
    assign ins_bad_pos = (ins_pos_ext > count_ext);
    assign rem_bad     = (count_reg == '0) || (rem_pos_ext >= count_ext);
    assign rem_last    = ((rem_pos_ext + sale_pkg::CMP_W'(1)) >= count_ext);

    assign mid_sum  = (sale_pkg::CNT_W + 1)'(lo_reg) + (sale_pkg::CNT_W + 1)'(hi_reg)
                      - (sale_pkg::CNT_W + 1)'(1);
    assign mid_calc = mid_sum[sale_pkg::ADDR_W:1];

    assign srch_hit  = (rd_rec.key == key_reg);
    assign srch_less = (rd_rec.key < key_reg);
    assign lo_step   = srch_less ? sale_pkg::CNT_W'(mid_reg) + sale_pkg::CNT_W'(1) : lo_reg;
    assign hi_step   = srch_less ? hi_reg : sale_pkg::CNT_W'(mid_reg);
    assign srch_end  = srch_hit || (lo_step >= hi_step);

    assign ins_end    = (i_reg == pos_reg + sale_pkg::CNT_W'(1));
    assign rem_end    = ((sale_pkg::CNT_W + 1)'(i_reg) + (sale_pkg::CNT_W + 1)'(2))
                        >= (sale_pkg::CNT_W + 1)'(count_reg);
    assign sort_end   = ((sale_pkg::CNT_W + 1)'(i_reg) + (sale_pkg::CNT_W + 1)'(1))
                        >= (sale_pkg::CNT_W + 1)'(count_reg);
    assign sort_shift = (key_reg < rd_rec.key);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        sale_pkg::ACT_APPEND, sale_pkg::ACT_INSERT:
                        begin
                            if (list_full || ins_bad_pos)
                                state_next = sale_pkg::S_FINISH;
                            else if (ins_pos_ext == count_ext)
                                state_next = sale_pkg::S_INS_PUT;
                            else
                                state_next = sale_pkg::S_INS_RD;
                        end
                        sale_pkg::ACT_REMOVE:
                        begin
                            if (rem_bad || rem_last)
                                state_next = sale_pkg::S_FINISH;
                            else
                                state_next = sale_pkg::S_REM_RD;
                        end
                        sale_pkg::ACT_SORT:
                        begin
                            if (count_reg <= sale_pkg::CNT_W'(1))
                                state_next = sale_pkg::S_FINISH;
                            else
                                state_next = sale_pkg::S_SORT_RD_I;
                        end
                        sale_pkg::ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                                state_next = sale_pkg::S_FINISH;
                            else
                                state_next = sale_pkg::S_SRCH_RD;
                        end
                        default:
                            state_next = sale_pkg::S_FINISH;
                    endcase
                end
            end
            sale_pkg::S_INS_RD:
                state_next = sale_pkg::S_INS_WR;
            sale_pkg::S_INS_WR:
                state_next = ins_end ? sale_pkg::S_INS_PUT : sale_pkg::S_INS_RD;
            sale_pkg::S_INS_PUT:
                state_next = sale_pkg::S_FINISH;
            sale_pkg::S_REM_RD:
                state_next = sale_pkg::S_REM_WR;
            sale_pkg::S_REM_WR:
                state_next = rem_end ? sale_pkg::S_FINISH : sale_pkg::S_REM_RD;
            sale_pkg::S_SORT_RD_I:
                state_next = sale_pkg::S_SORT_LD_I;
            sale_pkg::S_SORT_LD_I:
                state_next = sale_pkg::S_SORT_RD_J;
            sale_pkg::S_SORT_RD_J:
                state_next = sale_pkg::S_SORT_CMP;
            sale_pkg::S_SORT_CMP:
            begin
                if (sort_shift && (j_reg != sale_pkg::CNT_W'(1)))
                    state_next = sale_pkg::S_SORT_RD_J;
                else
                    state_next = sale_pkg::S_SORT_PUT;
            end
            sale_pkg::S_SORT_PUT:
                state_next = sort_end ? sale_pkg::S_FINISH : sale_pkg::S_SORT_RD_I;
            sale_pkg::S_SRCH_RD:
                state_next = sale_pkg::S_SRCH_CMP;
            sale_pkg::S_SRCH_CMP:
                state_next = srch_end ? sale_pkg::S_FINISH : sale_pkg::S_SRCH_RD;
            sale_pkg::S_FINISH:
            begin
                if (rsp_free)
                    state_next = sale_pkg::S_IDLE;
            end
            default:
                state_next = sale_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        fpay_next      = fpay_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        case (state_reg)
            sale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = req.entry_key;
                    pay_next    = req.entry_payload;
                    status_next = sale_pkg::ST_OK;
                    fidx_next   = '0;
                    fpay_next   = '0;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    case (req.action)
                        sale_pkg::ACT_APPEND, sale_pkg::ACT_INSERT:
                        begin
                            pos_next = sale_pkg::CNT_W'(ins_pos_ext);
                            i_next   = count_reg;
                            if (list_full)
                                status_next = sale_pkg::ST_FULL;
                            else if (ins_bad_pos)
                                status_next = sale_pkg::ST_INVALID;
                        end
                        sale_pkg::ACT_REMOVE:
                        begin
                            i_next = sale_pkg::CNT_W'(rem_pos_ext);
                            if (rem_bad)
                                status_next = sale_pkg::ST_INVALID;
                            else if (rem_last)
                                count_next = count_reg - sale_pkg::CNT_W'(1);
                        end
                        sale_pkg::ACT_SORT:
                            i_next = sale_pkg::CNT_W'(1);
                        sale_pkg::ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                                status_next = sale_pkg::ST_NOT_FOUND;
                        end
                        default:
                            status_next = sale_pkg::ST_INVALID;
                    endcase
                end
            end
            sale_pkg::S_INS_RD:
                ram_raddr = sale_pkg::ADDR_W'(i_reg - sale_pkg::CNT_W'(1));
            sale_pkg::S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[sale_pkg::ADDR_W-1:0];
                ram_wdata = rd_rec;
                i_next    = i_reg - sale_pkg::CNT_W'(1);
            end
            sale_pkg::S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[sale_pkg::ADDR_W-1:0];
                ram_wdata  = '{key: key_reg, payload: pay_reg};
                count_next = count_reg + sale_pkg::CNT_W'(1);
            end
            sale_pkg::S_REM_RD:
                ram_raddr = sale_pkg::ADDR_W'(i_reg + sale_pkg::CNT_W'(1));
            sale_pkg::S_REM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[sale_pkg::ADDR_W-1:0];
                ram_wdata = rd_rec;
                i_next    = i_reg + sale_pkg::CNT_W'(1);
                if (rem_end)
                    count_next = count_reg - sale_pkg::CNT_W'(1);
            end
            sale_pkg::S_SORT_RD_I:
                ram_raddr = i_reg[sale_pkg::ADDR_W-1:0];
            sale_pkg::S_SORT_LD_I:
            begin
                key_next = rd_rec.key;
                pay_next = rd_rec.payload;
                j_next   = i_reg;
            end
            sale_pkg::S_SORT_RD_J:
                ram_raddr = sale_pkg::ADDR_W'(j_reg - sale_pkg::CNT_W'(1));
            sale_pkg::S_SORT_CMP:
            begin
                if (sort_shift)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[sale_pkg::ADDR_W-1:0];
                    ram_wdata = rd_rec;
                    j_next    = j_reg - sale_pkg::CNT_W'(1);
                end
            end
            sale_pkg::S_SORT_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[sale_pkg::ADDR_W-1:0];
                ram_wdata = '{key: key_reg, payload: pay_reg};
                i_next    = i_reg + sale_pkg::CNT_W'(1);
            end
            sale_pkg::S_SRCH_RD:
            begin
                ram_raddr = mid_calc;
                mid_next  = mid_calc;
            end
            sale_pkg::S_SRCH_CMP:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (srch_hit)
                begin
                    fidx_next = 4'(mid_reg);
                    fpay_next = rd_rec.payload;
                end
                else if (srch_end)
                begin
                    status_next = sale_pkg::ST_NOT_FOUND;
                end
            end
            sale_pkg::S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.found_index  = fidx_reg;
                    rsp_next.found_payload = fpay_reg;
                    rsp_next.entry_count  = 5'(count_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sale_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        fpay_reg   <= fpay_next;
        rsp_reg    <= rsp_next;
    end

    `SALE_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= sale_pkg::CNT_W'(sale_pkg::DEPTH))
    `SALE_ASSERT_NEXT(a_count_holds_when_idle, (state_reg == sale_pkg::S_IDLE) && !accept, count_reg == $past(count_reg))
    `SALE_ASSERT_NEXT(a_finish_delivers, (state_reg == sale_pkg::S_FINISH) && rsp_free, rsp_valid_reg && (state_reg == sale_pkg::S_IDLE))
    `SALE_ASSERT_IMP(a_miss_has_no_match, rsp_valid_reg && (rsp_reg.status != sale_pkg::ST_OK), (rsp_reg.found_index == 4'd0) && (rsp_reg.found_payload == 32'd0))

endmodule
